@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions; expects clock and reset in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ hw/rtl/b64_pkg.sv @@
// ---------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the base64url codec.
// ---------------------------------------------------------------------------
package b64_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      JOB_ENC = 2'd0,
      JOB_DEC = 2'd1,
      JOB_ERR = 2'd2
   } job_kind_type;

   // results of one finished group, tail or error; chunk is top aligned
   typedef struct packed {
      job_kind_type kind;
      logic [23:0]  chunk;
      logic [1:0]   cnt_m1;
      logic         last;
   } job_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } dec_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] v8;
      v8 = {2'b00, v};
      if (v < 6'd26)      return 8'h41 + v8;
      else if (v < 6'd52) return 8'h61 + v8 - 8'd26;
      else if (v < 6'd62) return 8'h30 + v8 - 8'd52;
      else if (v == 6'd62) return 8'h2D;
      else                 return 8'h5F;
   endfunction

   function automatic dec_type dec_char(input logic [7:0] c);
      dec_type r;
      r.valid = 1'b1;
      r.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A)      r.value = 6'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) r.value = 6'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) r.value = 6'(c - 8'h30 + 8'd52);
      else if (c == 8'h2D)               r.value = 6'd62;
      else if (c == 8'h5F)               r.value = 6'd63;
      else                               r.valid = 1'b0;
      return r;
   endfunction

endpackage

@@ hw/rtl/base64url_stream_codec.sv @@
// ---------------------------------------------------------------------------
// base64url_stream_codec
// Unpadded base64url encoder/decoder over a stream of messages.
// ---------------------------------------------------------------------------
// An input transaction is taken whenever the job queue has room; the front
// end assembles groups and posts one job per finished group, tail or error.
// The output register emits one result per cycle unless rsp_tready is low,
// so throughput is set by the result port: encoding emits four characters
// per three input bytes, decoding one character per cycle. An input passes
// through the job queue and the output register before its first result
// appears. On an invalid character or a one-character tail a single result
// with tuser and tlast set is sent and the rest of the message is dropped.
// Write csr only while idle; a write also abandons any partial message.
module base64url_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_wdata,   // [0] decode_mode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_in
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_out
   output logic       rsp_tlast,   // out_last
   output logic       rsp_tuser    // [0] error
);

   logic             push, full, pop, empty;
   b64_pkg::job_type push_job, head_job;

   assign csr_ready  = 1'b1;
   assign req_tready = !full;

   b64_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_wdata(csr_wdata),
      .accept   (req_tvalid && req_tready),
      .data_in  (req_tdata),
      .in_last  (req_tlast),
      .push     (push),
      .push_job (push_job)
   );

   b64_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_job(push_job),
      .full    (full),
      .pop     (pop),
      .head_job(head_job),
      .empty   (empty)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .empty     (empty),
      .pop       (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

@@ hw/rtl/b64_fifo.sv @@
// ---------------------------------------------------------------------------
// b64_fifo
// Small job queue between the front (group assembly) and the back (emit).
// ---------------------------------------------------------------------------
module b64_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output b64_pkg::job_type head_job,
   output logic             empty
);

   b64_pkg::job_type mem [b64_pkg::QUEUE_DEPTH];
   logic [b64_pkg::QUEUE_AW:0] wr_ptr_ff, wr_ptr_in;
   logic [b64_pkg::QUEUE_AW:0] rd_ptr_ff, rd_ptr_in;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[b64_pkg::QUEUE_AW] != rd_ptr_ff[b64_pkg::QUEUE_AW]) &&
                  (wr_ptr_ff[b64_pkg::QUEUE_AW-1:0] == rd_ptr_ff[b64_pkg::QUEUE_AW-1:0]);
   assign head_job = mem[rd_ptr_ff[b64_pkg::QUEUE_AW-1:0]];

   assign wr_ptr_in = wr_ptr_ff + (b64_pkg::QUEUE_AW+1)'(push && !full);
   assign rd_ptr_in = rd_ptr_ff + (b64_pkg::QUEUE_AW+1)'(pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem[wr_ptr_ff[b64_pkg::QUEUE_AW-1:0]] <= push_job;
      end
   end

endmodule

@@ hw/rtl/b64_front.sv @@
// ---------------------------------------------------------------------------
// b64_front
// Accepts items, tracks the partial group and turns each finished group,
// tail or error into one job for the back end.
// ---------------------------------------------------------------------------
module b64_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic             csr_wdata,
   input  logic             accept,
   input  logic [7:0]       data_in,
   input  logic             in_last,
   output logic             push,
   output b64_pkg::job_type push_job
);

   logic        mode_ff, mode_in;
   logic [23:0] group_bits_ff, group_bits_in;
   logic [1:0]  group_count_ff, group_count_in;
   logic        dropping_ff, dropping_in;

   b64_pkg::dec_type dc;
   logic [23:0]      enc_bits, dec_bits;

   assign dc       = b64_pkg::dec_char(data_in);
   assign enc_bits = {group_bits_ff[15:0], data_in};
   assign dec_bits = {group_bits_ff[17:0], dc.value};

   always_comb begin
      mode_in        = mode_ff;
      group_bits_in  = group_bits_ff;
      group_count_in = group_count_ff;
      dropping_in    = dropping_ff;
      push           = 1'b0;
      push_job.kind   = b64_pkg::JOB_ENC;
      push_job.chunk  = enc_bits;
      push_job.cnt_m1 = 2'd3;
      push_job.last   = in_last;

      if (csr_valid) begin
         mode_in        = csr_wdata;
         group_bits_in  = '0;
         group_count_in = '0;
         dropping_in    = 1'b0;
      end else if (accept) begin
         if (dropping_ff) begin
            if (in_last) begin
               dropping_in    = 1'b0;
               group_bits_in  = '0;
               group_count_in = '0;
            end
         end else if (mode_ff) begin
            push_job.kind  = b64_pkg::JOB_DEC;
            push_job.chunk = dec_bits;
            if (!dc.valid) begin
               push            = 1'b1;
               push_job.kind   = b64_pkg::JOB_ERR;
               push_job.cnt_m1 = 2'd0;
               push_job.last   = 1'b1;
               group_bits_in   = '0;
               group_count_in  = '0;
               dropping_in     = !in_last;
            end else if (group_count_ff == 2'd3) begin
               push            = 1'b1;
               push_job.cnt_m1 = 2'd2;
               group_bits_in   = '0;
               group_count_in  = '0;
            end else if (in_last) begin
               push           = 1'b1;
               group_bits_in  = '0;
               group_count_in = '0;
               case (group_count_ff)
                  2'd0: begin
                     push_job.kind   = b64_pkg::JOB_ERR;
                     push_job.cnt_m1 = 2'd0;
                  end
                  2'd1: begin
                     push_job.chunk  = {dec_bits[11:0], 12'd0};
                     push_job.cnt_m1 = 2'd0;
                  end
                  default: begin
                     push_job.chunk  = {dec_bits[17:0], 6'd0};
                     push_job.cnt_m1 = 2'd1;
                  end
               endcase
            end else begin
               group_bits_in  = dec_bits;
               group_count_in = group_count_ff + 2'd1;
            end
         end else begin
            if (group_count_ff == 2'd2) begin
               push           = 1'b1;
               group_bits_in  = '0;
               group_count_in = '0;
            end else if (in_last) begin
               push           = 1'b1;
               group_bits_in  = '0;
               group_count_in = '0;
               if (group_count_ff == 2'd0) begin
                  push_job.chunk  = {data_in, 16'd0};
                  push_job.cnt_m1 = 2'd1;
               end else begin
                  push_job.chunk  = {enc_bits[15:0], 8'd0};
                  push_job.cnt_m1 = 2'd2;
               end
            end else begin
               group_bits_in  = enc_bits;
               group_count_in = group_count_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         group_bits_ff  <= '0;
         group_count_ff <= '0;
         dropping_ff    <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         dropping_ff    <= dropping_in;
      end
   end

endmodule

@@ hw/rtl/b64_back.sv @@
// ---------------------------------------------------------------------------
// b64_back
// Pops jobs into the output register, one result per cycle unless stalled.
// ---------------------------------------------------------------------------
module b64_back (
   input  logic             clock,
   input  logic             reset,
   input  b64_pkg::job_type head_job,
   input  logic             empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       load, final_one;
   logic [5:0] sextet;
   logic [7:0] byte_sel;

   assign load      = !valid_ff || rsp_tready;
   assign final_one = (idx_ff == head_job.cnt_m1);
   assign pop       = load && !empty && final_one;

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = head_job.chunk[23:18];
         2'd1:    sextet = head_job.chunk[17:12];
         2'd2:    sextet = head_job.chunk[11:6];
         default: sextet = head_job.chunk[5:0];
      endcase
      case (idx_ff)
         2'd0:    byte_sel = head_job.chunk[23:16];
         2'd1:    byte_sel = head_job.chunk[15:8];
         default: byte_sel = head_job.chunk[7:0];
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            idx_in  = final_one ? 2'd0 : idx_ff + 2'd1;
            last_in = final_one && head_job.last;
            err_in  = 1'b0;
            unique case (head_job.kind)
               b64_pkg::JOB_ENC: data_in = b64_pkg::enc_char(sextet);
               b64_pkg::JOB_DEC: data_in = byte_sel;
               b64_pkg::JOB_ERR: begin
                  data_in = 8'd0;
                  err_in  = 1'b1;
               end
               default: data_in = 8'd0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

endmodule

@@ hw/rtl/b64_checker.sv @@
// ---------------------------------------------------------------------------
// b64_checker
// Port-level checks on the codec's result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module b64_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   // error results close the message with zero data; the payload holds on stall
   `ASSERT_IMPLIES(a_err_last, rsp_tvalid && rsp_tuser, rsp_tlast, "error result without tlast")
   `ASSERT_IMPLIES(a_err_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 8'd0, "error data not zero")
   `ASSERT_NEXT(a_hold_valid, rsp_tvalid && !rsp_tready, rsp_tvalid, "tvalid dropped on stall")
   `ASSERT_NEXT(a_hold_data, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "payload changed on stall")

endmodule

bind base64url_stream_codec b64_checker u_b64_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .rsp_tuser (rsp_tuser)
);

@@ test/base64url_stream_codec_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// base64url_stream_codec_tb
// Self-checking bench for the unpadded base64url codec. A scoreboard class
// predicts every result from the accepted input transactions and the current
// mode. Directed messages hit tails, errors and mode aborts; random messages
// in both modes follow, with random stalls on both streams.
// ---------------------------------------------------------------------------
module base64url_stream_codec_tb;

   localparam bit MODE_ENCODE      = 1'b0;
   localparam bit MODE_DECODE      = 1'b1;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES     = 8;
   localparam int PHASE_ITEMS      = 12;
   localparam int HOLD_PHASE_ITEMS = 24;

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_wdata;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       rsp_tuser;

   bit quiet;
   bit hold_pending;
   bit cur_mode;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } codec_result_type;

   class b64_scoreboard_type;
      bit               decode_mode;
      bit [23:0]        group_bits;
      int unsigned      group_count;
      bit               dropping;
      codec_result_type pending_results[$];
      int unsigned      n_errors;
      int unsigned      n_inputs;
      int unsigned      n_results;
      int unsigned      n_flagged;
      int unsigned      n_mode_writes;

      static function bit [7:0] alpha_char(bit [5:0] v);
         string letters;
         letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
         return letters[v];
      endfunction

      // -1 for anything outside the url-safe alphabet
      static function int char_value(bit [7:0] c);
         if (c >= "A" && c <= "Z") return int'(c) - int'("A");
         if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
         if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
         if (c == "-") return 62;
         if (c == "_") return 63;
         return -1;
      endfunction

      function void clear_group();
         group_bits  = '0;
         group_count = 0;
      endfunction

      function void add_result(bit [7:0] d, bit l, bit e);
         codec_result_type r;
         r.data = d;
         r.last = l;
         r.err  = e;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void write_mode(bit m);
         decode_mode = m;
         dropping    = 1'b0;
         clear_group();
         n_mode_writes++;
      endfunction

      function void encode_byte(bit [7:0] d, bit l);
         bit [23:0] chunk;
         group_bits = {group_bits[15:0], d};
         group_count++;
         if (group_count == 3) begin
            add_result(alpha_char(group_bits[23:18]), 1'b0, 1'b0);
            add_result(alpha_char(group_bits[17:12]), 1'b0, 1'b0);
            add_result(alpha_char(group_bits[11:6]), 1'b0, 1'b0);
            add_result(alpha_char(group_bits[5:0]), l, 1'b0);
            clear_group();
         end else if (l) begin
            if (group_count == 1) begin
               chunk = {group_bits[7:0], 16'h0000};
               add_result(alpha_char(chunk[23:18]), 1'b0, 1'b0);
               add_result(alpha_char(chunk[17:12]), 1'b1, 1'b0);
            end else begin
               chunk = {group_bits[15:0], 8'h00};
               add_result(alpha_char(chunk[23:18]), 1'b0, 1'b0);
               add_result(alpha_char(chunk[17:12]), 1'b0, 1'b0);
               add_result(alpha_char(chunk[11:6]), 1'b1, 1'b0);
            end
            clear_group();
         end
      endfunction

      function void decode_char(bit [7:0] d, bit l);
         int        v;
         bit [23:0] chunk;
         v = char_value(d);
         if (v < 0) begin
            add_result(8'h00, 1'b1, 1'b1);
            clear_group();
            dropping = !l;
            return;
         end
         group_bits = {group_bits[17:0], v[5:0]};
         group_count++;
         if (group_count == 4) begin
            add_result(group_bits[23:16], 1'b0, 1'b0);
            add_result(group_bits[15:8], 1'b0, 1'b0);
            add_result(group_bits[7:0], l, 1'b0);
            clear_group();
         end else if (l) begin
            if (group_count == 1) begin
               add_result(8'h00, 1'b1, 1'b1);
            end else if (group_count == 2) begin
               chunk = {group_bits[11:0], 12'h000};
               add_result(chunk[23:16], 1'b1, 1'b0);
            end else begin
               chunk = {group_bits[17:0], 6'h00};
               add_result(chunk[23:16], 1'b0, 1'b0);
               add_result(chunk[15:8], 1'b1, 1'b0);
            end
            clear_group();
         end
      endfunction

      function void take_input(bit [7:0] d, bit l);
         n_inputs++;
         if (dropping) begin
            if (l) begin
               dropping = 1'b0;
               clear_group();
            end
            return;
         end
         if (decode_mode) decode_char(d, l);
         else encode_byte(d, l);
      endfunction

      function void report_field(string field, bit [7:0] want, bit [7:0] got);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         n_errors++;
      endfunction

      function void check_output(bit [7:0] d, bit l, bit e);
         codec_result_type want;
         n_results++;
         if (e) n_flagged++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual data %0h last %0b err %0b",
                     $time, d, l, e);
            n_errors++;
            return;
         end
         want = pending_results.pop_front();
         if (d != want.data) report_field("data", want.data, d);
         if (l != want.last) report_field("last", 8'(want.last), 8'(l));
         if (e != want.err) report_field("error", 8'(want.err), 8'(e));
      endfunction

      function void finish_check();
         if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived, expected data %0h first",
                     $time, pending_results.size(), pending_results[0].data);
            n_errors++;
         end
      endfunction
   endclass

   b64_scoreboard_type sb;

   base64url_stream_codec i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // monitor: every completed transaction goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (csr_valid && csr_ready) sb.write_mode(csr_wdata);
         if (req_tvalid && req_tready) sb.take_input(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_output(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // result side backpressure
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(bit [7:0] d, bit l);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
   endtask

   // mode changes only with the codec drained
   task automatic write_mode(bit m);
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_mode = m;
   endtask

   task automatic random_message(inout int sent, input bit with_last);
      int       len;
      bit [7:0] c;
      if (cur_mode == MODE_ENCODE) begin
         len = $urandom_range(1, 8);
      end else begin
         len = 4 * $urandom_range(0, 1) + $urandom_range(2, 4);
         if ($urandom_range(0, 7) == 0) len = 4 * $urandom_range(0, 1) + 1;
      end
      if (!with_last) len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
         if (cur_mode == MODE_ENCODE) begin
            c = 8'($urandom_range(0, 255));
         end else if ($urandom_range(0, 29) == 0) begin
            do c = 8'($urandom_range(0, 255));
            while (b64_scoreboard_type::char_value(c) >= 0);
         end else begin
            c = b64_scoreboard_type::alpha_char(6'($urandom_range(0, 63)));
         end
         send_item(c, with_last && i == len - 1);
         sent++;
      end
   endtask

   initial begin
      int sent;
      sb           = new();
      reset        = 1'b1;
      csr_valid    = 1'b0;
      csr_wdata    = 1'b0;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tlast    = 1'b0;
      quiet        = 1'b0;
      hold_pending = 1'b0;
      cur_mode     = MODE_ENCODE;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: encode tails, full group on the top of the alphabet
      write_mode(MODE_ENCODE);
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'hFB, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hBF, 1'b1);
      send_item(8'h55, 1'b0);      // left partial, mode write drops it
      write_mode(MODE_DECODE);
      send_text("TWFu");
      send_text("_w");
      send_text("-_8");
      send_text("Q");              // lone tail character
      send_text("A*BC");           // bad char mid message, rest dropped
      send_text("AB~");            // bad char on the last element
      send_item(8'hC1, 1'b0);      // starts dropping, mode write clears it
      write_mode(MODE_ENCODE);

      for (int ph = 0; ph < 6; ph++) begin
         quiet = (ph == 5);
         write_mode(ph % 2 ? MODE_DECODE : MODE_ENCODE);
         if (ph == 2) hold_pending = 1'b1;
         sent = 0;
         while (sent < (ph == 2 ? HOLD_PHASE_ITEMS : PHASE_ITEMS)) random_message(sent, 1'b1);
         if (!quiet && $urandom_range(0, 2) == 0) random_message(sent, 1'b0);
      end
      req_tvalid <= 1'b0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.finish_check();
      $display("Run covered %0d input and %0d result transactions (%0d flagged), %0d mode writes.",
               sb.n_inputs, sb.n_results, sb.n_flagged, sb.n_mode_writes);
      if (sb.n_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
